FILE: rtl/cau_pkg.sv
// Shared types, constants and helper functions for the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int W          = 32;
    localparam int CELL_STEPS = 32;
    localparam int R2_BITS    = W + FRAC_BITS;
    localparam int R2_STEPS   = (R2_BITS + 1) / 2;
    localparam int R2_SHIFT   = FRAC_BITS - 1 + (64 - 2 * R2_STEPS);
    localparam int NSTAGE     = 4 + CELL_STEPS + 1 + R2_STEPS + 1;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CONJ,
        OP_MAG,
        OP_SQRT,
        OP_SCALE
    } op_t;

    typedef struct packed {
        logic [63:0] d;
        logic [63:0] p_re;
        logic [63:0] p_im;
        logic [31:0] lo_re;
        logic [31:0] lo_im;
        logic [31:0] q_re;
        logic [31:0] q_im;
    } div_t;

    typedef struct packed {
        logic [63:0] x;
        logic [32:0] r;
        logic [31:0] q;
    } root_t;

    typedef struct packed {
        op_t                op;
        logic [31:0]        res_re;
        logic [31:0]        res_im;
        logic               sat;
        logic               dz;
        logic               ovf_re;
        logic               ovf_im;
        logic               neg_re;
        logic               neg_im;
        logic               a_im_neg;
        logic signed [31:0] a_re;
    } side_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } pack_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } split_t;

    function automatic split_t split(input logic signed [64:0] v);
        split_t s;
        logic signed [64:0] n;
        n = -v;
        s.neg = v[64];
        s.mag = v[64] ? n[63:0] : v[63:0];
        return s;
    endfunction

    function automatic pack_t pack32(input logic neg, input logic [63:0] mag);
        pack_t p;
        logic [63:0] n;
        n = 64'd0 - mag;
        p.sat = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                p.val = 32'h8000_0000;
                p.sat = 1'b1;
            end else begin
                p.val = n[31:0];
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                p.val = 32'h7FFF_FFFF;
                p.sat = 1'b1;
            end else begin
                p.val = mag[31:0];
            end
        end
        return p;
    endfunction

endpackage

FILE: rtl/cau_div_cell.sv
// One restoring division step on both quotient parts, registered.
module cau_div_cell (
    input  logic          clk,
    input  logic          en,
    input  cau_pkg::div_t din,
    output cau_pkg::div_t dout
);

    cau_pkg::div_t cell_reg;
    cau_pkg::div_t cell_next;
    logic [64:0]   t_re;
    logic [64:0]   t_im;
    logic [65:0]   dif_re;
    logic [65:0]   dif_im;

    always_comb
    begin
        cell_next = din;
        t_re      = {din.p_re, din.lo_re[31]};
        t_im      = {din.p_im, din.lo_im[31]};
        dif_re    = {1'b0, t_re} - {2'b00, din.d};
        dif_im    = {1'b0, t_im} - {2'b00, din.d};
        cell_next.p_re  = dif_re[65] ? t_re[63:0] : dif_re[63:0];
        cell_next.p_im  = dif_im[65] ? t_im[63:0] : dif_im[63:0];
        cell_next.q_re  = {din.q_re[30:0], ~dif_re[65]};
        cell_next.q_im  = {din.q_im[30:0], ~dif_im[65]};
        cell_next.lo_re = {din.lo_re[30:0], 1'b0};
        cell_next.lo_im = {din.lo_im[30:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

FILE: rtl/cau_root_cell.sv
// One digit-pair step of the integer square root, registered.
module cau_root_cell (
    input  logic           clk,
    input  logic           en,
    input  cau_pkg::root_t din,
    output cau_pkg::root_t dout
);

    cau_pkg::root_t cell_reg;
    cau_pkg::root_t cell_next;
    logic [34:0]    t;
    logic [34:0]    trial;
    logic [35:0]    dif;

    always_comb
    begin
        cell_next   = din;
        t           = {din.r, din.x[63:62]};
        trial       = {1'b0, din.q, 2'b01};
        dif         = {1'b0, t} - {1'b0, trial};
        cell_next.r = dif[35] ? t[32:0] : dif[32:0];
        cell_next.q = {din.q[30:0], ~dif[35]};
        cell_next.x = {din.x[61:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: operand pipeline, cell chains, result register.
//
// Fully pipelined: one request is taken every cycle while the pipeline is not held, and each
// result passes through 62 register stages (4 front stages, 32 division / root cells,
// one stage that forms the half-norm radicands, 24 cells for the second root and the
// result register). The depth is set by the bit-per-cell division and
// digit-pair-per-cell square root chains. Every opcode takes the same path, so results
// leave in request order. When a result waits at the output the whole pipeline holds; a
// bubble in the last stage lets it move on.
module complex_arithmetic_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               saturated,
    output logic               divide_by_zero
);

    localparam int N = cau_pkg::NSTAGE;
    localparam int C = cau_pkg::CELL_STEPS;
    localparam int R = cau_pkg::R2_STEPS;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic         adv;

    cau_pkg::op_t       a_op_reg;
    logic signed [31:0] a_re_reg;
    logic signed [31:0] a_im_reg;
    logic signed [31:0] b_re_reg;
    logic signed [31:0] b_im_reg;

    logic signed [63:0] m_reg [6];
    logic signed [63:0] m_next [6];
    cau_pkg::side_t     b_side_reg;
    cau_pkg::side_t     b_side_next;

    logic signed [64:0] c_wre_reg;
    logic signed [64:0] c_wre_next;
    logic signed [64:0] c_wim_reg;
    logic signed [64:0] c_wim_next;
    logic [63:0]        c_d_reg;
    logic [63:0]        c_d_next;
    cau_pkg::side_t     c_side_reg;

    cau_pkg::div_t      d_div_reg;
    cau_pkg::div_t      d_div_next;
    cau_pkg::root_t     d_root_reg;
    cau_pkg::root_t     d_root_next;
    cau_pkg::side_t     d_side_reg;
    cau_pkg::side_t     d_side_next;

    cau_pkg::div_t      div_q [C+1];
    cau_pkg::root_t     root_q [C+1];
    cau_pkg::side_t     cell_side_reg [C];

    cau_pkg::root_t     mid_re_reg;
    cau_pkg::root_t     mid_re_next;
    cau_pkg::root_t     mid_im_reg;
    cau_pkg::root_t     mid_im_next;
    cau_pkg::side_t     mid_side_reg;
    cau_pkg::side_t     mid_side_next;

    cau_pkg::root_t     r2re_q [R+1];
    cau_pkg::root_t     r2im_q [R+1];
    cau_pkg::side_t     r2_side_reg [R];

    cau_pkg::side_t     out_side_reg;
    cau_pkg::side_t     out_side_next;

    logic signed [31:0] mul_b0;
    logic signed [31:0] mul_b1;
    cau_pkg::split_t    q_re_s;
    cau_pkg::split_t    q_im_s;
    cau_pkg::pack_t     q_re_p;
    cau_pkg::pack_t     q_im_p;
    cau_pkg::split_t    sre;
    cau_pkg::split_t    sim;
    cau_pkg::pack_t     d_re_p;
    cau_pkg::pack_t     d_im_p;
    cau_pkg::side_t     sc;
    cau_pkg::pack_t     mid_re_p;
    cau_pkg::pack_t     mid_im_p;
    logic signed [33:0] tp;
    logic signed [33:0] tm;
    cau_pkg::side_t     sr;
    cau_pkg::pack_t     fin_re_p;
    cau_pkg::pack_t     fin_im_p;

    assign adv       = ~valid_reg[N-1] | res_ready;
    assign req_ready = adv;
    assign res_valid = valid_reg[N-1];

    assign valid_next = adv ? {valid_reg[N-2:0], req_valid} : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // request register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg <= cau_pkg::op_t'(req_type);
            a_re_reg <= a_re;
            a_im_reg <= a_im;
            b_re_reg <= b_re;
            b_im_reg <= b_im;
        end
    end

    // products and the single-step operations
    always_comb
    begin
        mul_b0 = ((a_op_reg == cau_pkg::OP_MAG) || (a_op_reg == cau_pkg::OP_SQRT))
                 ? a_re_reg : b_re_reg;
        mul_b1 = ((a_op_reg == cau_pkg::OP_MAG) || (a_op_reg == cau_pkg::OP_SQRT))
                 ? a_im_reg : b_im_reg;
        m_next[0] = 64'(a_re_reg) * 64'(mul_b0);
        m_next[1] = 64'(a_im_reg) * 64'(mul_b1);
        m_next[2] = 64'(a_re_reg) * 64'(b_im_reg);
        m_next[3] = 64'(a_im_reg) * 64'(b_re_reg);
        m_next[4] = 64'(b_re_reg) * 64'(b_re_reg);
        m_next[5] = 64'(b_im_reg) * 64'(b_im_reg);

        q_re_s = '0;
        q_im_s = '0;
        case (a_op_reg)
            cau_pkg::OP_ADD:
            begin
                q_re_s = cau_pkg::split(65'(a_re_reg) + 65'(b_re_reg));
                q_im_s = cau_pkg::split(65'(a_im_reg) + 65'(b_im_reg));
            end
            cau_pkg::OP_SUB:
            begin
                q_re_s = cau_pkg::split(65'(a_re_reg) - 65'(b_re_reg));
                q_im_s = cau_pkg::split(65'(a_im_reg) - 65'(b_im_reg));
            end
            cau_pkg::OP_CONJ:
            begin
                q_re_s = cau_pkg::split(65'(a_re_reg));
                q_im_s = cau_pkg::split(-65'(a_im_reg));
            end
            default:
            begin
                q_re_s = '0;
                q_im_s = '0;
            end
        endcase
        q_re_p = cau_pkg::pack32(q_re_s.neg, q_re_s.mag);
        q_im_p = cau_pkg::pack32(q_im_s.neg, q_im_s.mag);

        b_side_next          = '0;
        b_side_next.op       = a_op_reg;
        b_side_next.res_re   = q_re_p.val;
        b_side_next.res_im   = q_im_p.val;
        b_side_next.sat      = q_re_p.sat | q_im_p.sat;
        b_side_next.a_im_neg = a_im_reg[31];
        b_side_next.a_re     = a_re_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 6; k++)
            begin
                m_reg[k] <= m_next[k];
            end
            b_side_reg <= b_side_next;
        end
    end

    // wide sums
    always_comb
    begin
        case (b_side_reg.op) inside
            cau_pkg::OP_MUL:
            begin
                c_wre_next = 65'(m_reg[0]) - 65'(m_reg[1]);
                c_wim_next = 65'(m_reg[2]) + 65'(m_reg[3]);
            end
            cau_pkg::OP_SCALE:
            begin
                c_wre_next = 65'(m_reg[0]);
                c_wim_next = 65'(m_reg[3]);
            end
            cau_pkg::OP_DIV:
            begin
                c_wre_next = 65'(m_reg[0]) + 65'(m_reg[1]);
                c_wim_next = 65'(m_reg[3]) - 65'(m_reg[2]);
            end
            cau_pkg::OP_MAG, cau_pkg::OP_SQRT:
            begin
                c_wre_next = 65'(m_reg[0]) + 65'(m_reg[1]);
                c_wim_next = '0;
            end
            default:
            begin
                c_wre_next = '0;
                c_wim_next = '0;
            end
        endcase
        c_d_next = $unsigned(m_reg[4]) + $unsigned(m_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_wre_reg  <= c_wre_next;
            c_wim_reg  <= c_wim_next;
            c_d_reg    <= c_d_next;
            c_side_reg <= b_side_reg;
        end
    end

    // sign/magnitude split, product scaling, divider and root setup
    always_comb
    begin
        sre    = cau_pkg::split(c_wre_reg);
        sim    = cau_pkg::split(c_wim_reg);
        d_re_p = cau_pkg::pack32(sre.neg, sre.mag >> cau_pkg::FRAC_BITS);
        d_im_p = cau_pkg::pack32(sim.neg, sim.mag >> cau_pkg::FRAC_BITS);

        d_side_next        = c_side_reg;
        d_side_next.neg_re = sre.neg;
        d_side_next.neg_im = sim.neg;
        d_side_next.dz     = (c_side_reg.op == cau_pkg::OP_DIV) && (c_d_reg == 64'd0);
        d_side_next.ovf_re = (sre.mag >> (cau_pkg::W - cau_pkg::FRAC_BITS)) >= c_d_reg;
        d_side_next.ovf_im = (sim.mag >> (cau_pkg::W - cau_pkg::FRAC_BITS)) >= c_d_reg;
        if ((c_side_reg.op == cau_pkg::OP_MUL) || (c_side_reg.op == cau_pkg::OP_SCALE))
        begin
            d_side_next.res_re = d_re_p.val;
            d_side_next.res_im = d_im_p.val;
            d_side_next.sat    = d_re_p.sat | d_im_p.sat;
        end

        d_div_next.d     = c_d_reg;
        d_div_next.p_re  = sre.mag >> (cau_pkg::W - cau_pkg::FRAC_BITS);
        d_div_next.p_im  = sim.mag >> (cau_pkg::W - cau_pkg::FRAC_BITS);
        d_div_next.lo_re = 32'(sre.mag << cau_pkg::FRAC_BITS);
        d_div_next.lo_im = 32'(sim.mag << cau_pkg::FRAC_BITS);
        d_div_next.q_re  = '0;
        d_div_next.q_im  = '0;

        d_root_next.x = c_wre_reg[63:0];
        d_root_next.r = '0;
        d_root_next.q = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_div_reg  <= d_div_next;
            d_root_reg <= d_root_next;
            d_side_reg <= d_side_next;
        end
    end

    assign div_q[0]  = d_div_reg;
    assign root_q[0] = d_root_reg;

    genvar k;
    generate
        for (k = 0; k < C; k++)
        begin : g_cell
            cau_div_cell u_div (
                .clk  (clk),
                .en   (adv),
                .din  (div_q[k]),
                .dout (div_q[k+1])
            );
            cau_root_cell u_root (
                .clk  (clk),
                .en   (adv),
                .din  (root_q[k]),
                .dout (root_q[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cell_side_reg[0] <= d_side_reg;
            for (int j = 1; j < C; j++)
            begin
                cell_side_reg[j] <= cell_side_reg[j-1];
            end
        end
    end

    // quotient and magnitude results, half-norm radicands for the square root
    always_comb
    begin
        sc       = cell_side_reg[C-1];
        mid_re_p = cau_pkg::pack32(sc.neg_re,
                                   sc.ovf_re ? 64'h1_0000_0000 : {32'd0, div_q[C].q_re});
        mid_im_p = cau_pkg::pack32(sc.neg_im,
                                   sc.ovf_im ? 64'h1_0000_0000 : {32'd0, div_q[C].q_im});
        tp = $signed({2'b00, root_q[C].q}) + 34'(sc.a_re);
        tm = $signed({2'b00, root_q[C].q}) - 34'(sc.a_re);

        mid_side_next = sc;
        case (sc.op)
            cau_pkg::OP_DIV:
            begin
                if (sc.dz)
                begin
                    mid_side_next.res_re = '0;
                    mid_side_next.res_im = '0;
                    mid_side_next.sat    = 1'b0;
                end
                else
                begin
                    mid_side_next.res_re = mid_re_p.val;
                    mid_side_next.res_im = mid_im_p.val;
                    mid_side_next.sat    = mid_re_p.sat | mid_im_p.sat;
                end
            end
            cau_pkg::OP_MAG:
            begin
                mid_re_p             = cau_pkg::pack32(1'b0, {32'd0, root_q[C].q});
                mid_side_next.res_re = mid_re_p.val;
                mid_side_next.res_im = '0;
                mid_side_next.sat    = mid_re_p.sat;
            end
            default:
            begin
                mid_side_next = sc;
            end
        endcase

        mid_re_next.x = 64'(tp[32:0]) << cau_pkg::R2_SHIFT;
        mid_re_next.r = '0;
        mid_re_next.q = '0;
        mid_im_next.x = 64'(tm[32:0]) << cau_pkg::R2_SHIFT;
        mid_im_next.r = '0;
        mid_im_next.q = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mid_re_reg   <= mid_re_next;
            mid_im_reg   <= mid_im_next;
            mid_side_reg <= mid_side_next;
        end
    end

    assign r2re_q[0] = mid_re_reg;
    assign r2im_q[0] = mid_im_reg;

    generate
        for (k = 0; k < R; k++)
        begin : g_root2
            cau_root_cell u_re (
                .clk  (clk),
                .en   (adv),
                .din  (r2re_q[k]),
                .dout (r2re_q[k+1])
            );
            cau_root_cell u_im (
                .clk  (clk),
                .en   (adv),
                .din  (r2im_q[k]),
                .dout (r2im_q[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_side_reg[0] <= mid_side_reg;
            for (int j = 1; j < R; j++)
            begin
                r2_side_reg[j] <= r2_side_reg[j-1];
            end
        end
    end

    // result register
    always_comb
    begin
        sr       = r2_side_reg[R-1];
        fin_re_p = cau_pkg::pack32(1'b0, {32'd0, r2re_q[R].q});
        fin_im_p = cau_pkg::pack32(sr.a_im_neg, {32'd0, r2im_q[R].q});
        out_side_next = sr;
        if (sr.op == cau_pkg::OP_SQRT)
        begin
            out_side_next.res_re = fin_re_p.val;
            out_side_next.res_im = fin_im_p.val;
            out_side_next.sat    = fin_re_p.sat | fin_im_p.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_side_reg <= out_side_next;
        end
    end

    assign res_re         = out_side_reg.res_re;
    assign res_im         = out_side_reg.res_im;
    assign saturated      = out_side_reg.sat;
    assign divide_by_zero = out_side_reg.dz;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (res_valid && !res_ready))
        else $error("pipeline held without a stalled result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && divide_by_zero) |->
            (out_side_reg.op == cau_pkg::OP_DIV && res_re == 0 && res_im == 0 && !saturated))
        else $error("zero divisor result malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_side_reg.op == cau_pkg::OP_MAG) |-> (res_im == 0 && !res_re[31]))
        else $error("magnitude result malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_side_reg.op == cau_pkg::OP_SQRT) |-> !res_re[31])
        else $error("principal root has negative real part");
`endif

endmodule
